// ----- src/ngo_pkg.sv -----
// Shared types, codes and constants of the note glide oscillator.
`timescale 1ns / 1ps
package ngo_pkg;

  // Serial divider widths
  localparam int DVD_W = 64;
  localparam int DVS_W = 44;

  // Configuration register indexes
  localparam logic [2:0] CFG_TEMPO  = 3'd0;
  localparam logic [2:0] CFG_START  = 3'd1;
  localparam logic [2:0] CFG_LENGTH = 3'd2;
  localparam logic [2:0] CFG_SPITCH = 3'd3;
  localparam logic [2:0] CFG_EPITCH = 3'd4;

  // Waveform selector
  localparam logic [1:0] OP_SINE   = 2'd0;
  localparam logic [1:0] OP_SAW    = 2'd1;
  localparam logic [1:0] OP_SQUARE = 2'd2;

  // Note status
  localparam logic [1:0] ST_BEFORE = 2'd0;
  localparam logic [1:0] ST_SOUND  = 2'd1;
  localparam logic [1:0] ST_AFTER  = 2'd2;

  // One octave of pitch in Q7.16, and 13.75 Hz in Q16.16
  localparam logic [23:0] OCT_STEP  = 24'd786432;
  localparam logic [19:0] BASE_FREQ = 20'd901120;

  // Sine polynomial coefficients
  localparam logic [15:0] SIN_A = 16'd51472;
  localparam logic [15:0] SIN_B = 16'd21024;
  localparam logic [11:0] SIN_C = 12'd2320;

  // round(2^(k/12) * 2^16)
  localparam logic [17:0] SEMI_Q16 [13] = '{
    18'd65536, 18'd69433, 18'd73562, 18'd77936, 18'd82570, 18'd87480, 18'd92682,
    18'd98193, 18'd104032, 18'd110218, 18'd116772, 18'd123715, 18'd131072
  };

endpackage

// ----- src/ngo_div.sv -----
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ngo_div
  import ngo_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quot_o,
  output logic [DVS_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W-1:0] dvs_q, rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q, ge;
  logic [DVS_W:0]   shifted;

  assign shifted = {rem_q, dvd_q[DVD_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  always_comb begin
    if (ge) begin
      rem_d = DVS_W'(shifted - {1'b0, dvs_q});
    end else begin
      rem_d = DVS_W'(shifted);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (go_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

// ----- src/ngo_mulmod.sv -----
// Bit-serial modular multiply, multiplier MSB first, double then add.
`timescale 1ns / 1ps
module ngo_mulmod
  import ngo_pkg::*;
#(
  parameter int B_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  logic [DVS_W-1:0] a_i,
  input  logic [B_W-1:0]   b_i,
  input  logic [DVS_W-1:0] m_i,
  output logic             done_o,
  output logic [DVS_W-1:0] r_o
);

  localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

  logic [DVS_W-1:0] a_q, m_q, r_q, r_d;
  logic [B_W-1:0]   b_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q, add_q;
  logic [DVS_W:0]   t;

  // doubling step, then conditional add step
  always_comb begin
    if (add_q) begin
      t = b_q[B_W-1] ? ({1'b0, r_q} + {1'b0, a_q}) : {1'b0, r_q};
    end else begin
      t = {r_q, 1'b0};
    end
    if (t >= {1'b0, m_q}) begin
      r_d = DVS_W'(t - {1'b0, m_q});
    end else begin
      r_d = DVS_W'(t);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      add_q  <= 1'b0;
      cnt_q  <= '0;
    end else if (go_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      add_q  <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      add_q <= ~add_q;
      if (add_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(B_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      a_q <= a_i;
      b_q <= b_i;
      m_q <= m_i;
      r_q <= '0;
    end else if (busy_q) begin
      r_q <= r_d;
      if (add_q) begin
        b_q <= b_q << 1;
      end
    end
  end

  assign done_o = done_q;
  assign r_o    = r_q;

endmodule

// ----- src/ngo_sine.sv -----
// Polynomial sine of a 16-bit phase, one multiply per cycle.
`timescale 1ns / 1ps
module ngo_sine
  import ngo_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               go_i,
  input  logic [15:0]        ph_i,
  output logic               done_o,
  output logic signed [15:0] y_o
);

  logic        busy_q, done_q, neg_q;
  logic [1:0]  step_q;
  logic [16:0] x_q, x2_q, xin;
  logic [15:0] t2_q, t4_q;
  logic signed [15:0] y_q;
  logic [33:0] p0;
  logic [28:0] p1;
  logic [32:0] p2, p3;
  logic [17:0] y_raw;
  logic [14:0] y_cap;

  assign xin   = ph_i[14] ? (17'd32768 - {2'b0, ph_i[13:0], 1'b0})
                          : {2'b0, ph_i[13:0], 1'b0};
  assign p0    = 34'(x_q) * 34'(x_q);
  assign p1    = 29'(x2_q) * 29'(SIN_C);
  assign p2    = 33'(x2_q) * 33'(t2_q);
  assign p3    = 33'(x_q) * 33'(t4_q);
  assign y_raw = p3[32:15];
  assign y_cap = (y_raw > 18'd32767) ? 15'h7FFF : y_raw[14:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (go_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == 2'd3) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      x_q   <= xin;
      neg_q <= ph_i[15];
    end else if (busy_q) begin
      case (step_q)
        2'd0:    x2_q <= p0[31:15];
        2'd1:    t2_q <= SIN_B - 16'(p1[28:15]);
        2'd2:    t4_q <= SIN_A - 16'(p2[32:15]);
        default: y_q  <= neg_q ? -$signed({1'b0, y_cap}) : $signed({1'b0, y_cap});
      endcase
    end
  end

  assign done_o = done_q;
  assign y_o    = y_q;

endmodule

// ----- src/note_glide_oscillator.sv -----
// Top level of the note glide oscillator: one gliding note, one sample per tick.
//
// Channel  | Dir | Content
// s_axis   | in  | tdata: harmonic[15:0] (Q8.8), restart[16]; tuser: operation[1:0]
// m_axis   | out | tdata: sample[15:0] (Q1.15), frame_index[47:16]; tuser: note_status[1:0]
// cfg      | in  | cfg_we_i, cfg_idx_i (register index), cfg_data_i
//
// The length of a sounding tick is set by the shared serial divider (note edges,
// glide, phase reduction, sine phase), the bit-serial phase multiply and the
// octave steps. A tick outside the note skips the glide and the octave steps.
// One tick is worked at a time.
// Reset: frame counter all ones (next tick gives frame 0), held frequency zero.
// The finished sample sits in the output register; the next transfer is taken
// while it waits, and the tick only stalls at its end if that register is full.
`timescale 1ns / 1ps
module note_glide_oscillator
  import ngo_pkg::*;
#(
  parameter int SAMPLE_RATE = 44100,
  parameter int FRAME_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // harmonic[15:0], restart[16], zero pad
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // sample[15:0], frame_index[47:16]
  output logic [1:0]  m_axis_tuser,   // note_status[1:0]
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [23:0]      SR60 = 24'(SAMPLE_RATE * 60);
  localparam logic [DVS_W-1:0] M1   = DVS_W'(SAMPLE_RATE) << 24;
  localparam logic [DVS_W-1:0] M2   = M1 << 1;

  // sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SF    = 4'd1;
  localparam logic [3:0] S_EF    = 4'd2;
  localparam logic [3:0] S_CMP   = 4'd3;
  localparam logic [3:0] S_QW    = 4'd4;
  localparam logic [3:0] S_PITCH = 4'd5;
  localparam logic [3:0] S_OCT   = 4'd6;
  localparam logic [3:0] S_G1    = 4'd7;
  localparam logic [3:0] S_G2    = 4'd8;
  localparam logic [3:0] S_G3    = 4'd9;
  localparam logic [3:0] S_PM    = 4'd10;
  localparam logic [3:0] S_PMW   = 4'd11;
  localparam logic [3:0] S_MMW   = 4'd12;
  localparam logic [3:0] S_PHW   = 4'd13;
  localparam logic [3:0] S_SINW  = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  // configuration
  logic [8:0]  tempo_q;
  logic [15:0] nstart_q, nlen_q;
  logic [6:0]  spitch_q, epitch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tempo_q  <= 9'd120;
      nstart_q <= 16'd0;
      nlen_q   <= 16'd16;
      spitch_q <= 7'd69;
      epitch_q <= 7'd69;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TEMPO:  tempo_q  <= cfg_data_i[8:0];
        CFG_START:  nstart_q <= cfg_data_i;
        CFG_LENGTH: nlen_q   <= cfg_data_i;
        CFG_SPITCH: spitch_q <= cfg_data_i[6:0];
        CFG_EPITCH: epitch_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  logic [3:0]            state_q;
  logic [FRAME_BITS-1:0] frame_q;
  logic [31:0]           held_q;
  logic [1:0]            op_q, status_q;
  logic [15:0]           harm_q, ph_q;
  logic [40:0]           sf_q, ef_q;
  logic [22:0]           q_q;
  logic [23:0]           pq_q;
  logic [3:0]            oct_q;
  logic [17:0]           g_q;
  logic [20:0]           base_q;
  logic                  saw_hi_q;
  logic signed [15:0]    sine_q;

  // shared divider and serial multiply
  logic [DVD_W-1:0] dvd_q, div_quot;
  logic [DVS_W-1:0] dvs_q, div_rem, mm_a_q, mm_r;
  logic             div_go_q, div_done, mm_go_q, mm_done, sin_go_q, sin_done;
  logic signed [15:0] sin_y;

  ngo_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (div_go_q),
    .dividend_i (dvd_q),
    .divisor_i  (dvs_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  ngo_mulmod #(.B_W(FRAME_BITS)) u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (mm_go_q),
    .a_i    (mm_a_q),
    .b_i    (frame_q),
    .m_i    (M2),
    .done_o (mm_done),
    .r_o    (mm_r)
  );

  ngo_sine u_sine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (sin_go_q),
    .ph_i   (ph_q),
    .done_o (sin_done),
    .y_o    (sin_y)
  );

  // note edges in frames
  logic [8:0]  bpm;
  logic [12:0] den;
  logic [40:0] num_s, num_e, frame_ext, span, pdiff;
  logic [38:0] pmag;
  logic [6:0]  mag;
  logic [1:0]  status_d;

  assign bpm       = (tempo_q == 9'd0) ? 9'd1 : tempo_q;
  assign den       = {bpm, 4'b0};
  assign num_s     = 41'(nstart_q) * 41'(SR60);
  assign num_e     = (41'(nstart_q) + 41'(nlen_q)) * 41'(SR60);
  assign frame_ext = 41'(frame_q);
  assign span      = ef_q - sf_q;
  assign pdiff     = frame_ext - sf_q;
  assign mag       = (spitch_q > epitch_q) ? (spitch_q - epitch_q) : (epitch_q - spitch_q);
  assign pmag      = 39'(pdiff[31:0]) * 39'(mag);

  always_comb begin
    if (frame_ext < sf_q) begin
      status_d = ST_BEFORE;
    end else if (frame_ext > ef_q) begin
      status_d = ST_AFTER;
    end else begin
      status_d = ST_SOUND;
    end
  end

  // glide pitch, clamped below at one semitone
  logic [23:0] pq_d;
  always_comb begin
    if (epitch_q >= spitch_q) begin
      pq_d = {1'b0, spitch_q, 16'b0} + 24'(q_q);
    end else begin
      pq_d = {1'b0, spitch_q, 16'b0} - 24'(q_q);
    end
    if (pq_d < 24'd65536) begin
      pq_d = 24'd65536;
    end
  end

  // semitone interpolation
  logic [3:0]  k;
  logic [17:0] tk, tk1;
  logic [12:0] tdiff;
  logic [28:0] interp;
  logic [37:0] base_full;
  logic [31:0] held_d;

  assign k         = pq_q[19:16];
  assign tk        = SEMI_Q16[k];
  assign tk1       = SEMI_Q16[k + 4'd1];
  assign tdiff     = 13'(tk1 - tk);
  assign interp    = 29'(tdiff) * 29'(pq_q[15:0]);
  assign base_full = 38'(BASE_FREQ) * 38'(g_q);
  assign held_d    = 32'(base_q) << oct_q;

  // phase
  logic [47:0]      prod_p;
  logic [DVS_W-1:0] r1;
  logic             r2_hi;

  assign prod_p = 48'(harm_q) * 48'(held_q);
  assign r2_hi  = mm_r >= M1;
  assign r1     = r2_hi ? (mm_r - M1) : mm_r;

  logic out_free;
  logic [15:0] sample_d;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    case (op_q)
      OP_SINE:   sample_d = sine_q;
      OP_SAW:    sample_d = {~saw_hi_q, ph_q[15:1]};
      OP_SQUARE: sample_d = (sine_q > 16'sd0) ? 16'h7FFF : 16'h8000;
      default:   sample_d = 16'h0000;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);

  // start pulses for the serial units
  logic div_go_d, mm_go_d, sin_go_d;
  always_comb begin
    div_go_d = 1'b0;
    mm_go_d  = 1'b0;
    sin_go_d = 1'b0;
    case (state_q)
      S_IDLE:  div_go_d = s_axis_tvalid;
      S_SF:    div_go_d = div_done;
      S_CMP:   div_go_d = (status_d == ST_SOUND) && (span != '0);
      S_PM:    div_go_d = 1'b1;
      S_PMW:   mm_go_d  = div_done;
      S_MMW:   div_go_d = mm_done;
      S_PHW:   sin_go_d = div_done;
      default: ;
    endcase
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      frame_q       <= '1;
      held_q        <= '0;
      div_go_q      <= 1'b0;
      mm_go_q       <= 1'b0;
      sin_go_q      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      div_go_q <= div_go_d;
      mm_go_q  <= mm_go_d;
      sin_go_q <= sin_go_d;
      if (state_q == S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            if (s_axis_tdata[16] || frame_q == '1) begin
              frame_q <= '0;
            end else if (frame_q < {{(FRAME_BITS-1){1'b1}}, 1'b0}) begin
              frame_q <= frame_q + 1'b1;
            end
            state_q <= S_SF;
          end
        end
        S_SF:    if (div_done) state_q <= S_EF;
        S_EF:    if (div_done) state_q <= S_CMP;
        S_CMP: begin
          if (status_d != ST_SOUND) begin
            state_q <= S_PM;
          end else if (span == '0) begin
            state_q <= S_PITCH;
          end else begin
            state_q <= S_QW;
          end
        end
        S_QW:    if (div_done) state_q <= S_PITCH;
        S_PITCH: state_q <= S_OCT;
        S_OCT:   if (pq_q < OCT_STEP) state_q <= S_G1;
        S_G1:    state_q <= S_G2;
        S_G2:    state_q <= S_G3;
        S_G3: begin
          held_q  <= held_d;
          state_q <= S_PM;
        end
        S_PM:    state_q <= S_PMW;
        S_PMW:   if (div_done) state_q <= S_MMW;
        S_MMW:   if (mm_done) state_q <= S_PHW;
        S_PHW:   if (div_done) state_q <= S_SINW;
        S_SINW:  if (sin_done) state_q <= S_DONE;
        S_DONE:  if (out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q   <= s_axis_tuser;
        harm_q <= s_axis_tdata[15:0];
        dvd_q  <= DVD_W'(num_s);
        dvs_q  <= DVS_W'(den);
      end
      S_SF: begin
        sf_q  <= div_quot[40:0];
        dvd_q <= DVD_W'(num_e);
        dvs_q <= DVS_W'(den);
      end
      S_EF:  ef_q <= div_quot[40:0];
      S_CMP: begin
        status_q <= status_d;
        q_q      <= '0;
        dvd_q    <= DVD_W'({pmag, 16'b0});
        dvs_q    <= DVS_W'(span);
      end
      S_QW: q_q <= div_quot[22:0];
      S_PITCH: begin
        pq_q  <= pq_d;
        oct_q <= '0;
      end
      S_OCT: begin
        if (pq_q >= OCT_STEP) begin
          pq_q  <= pq_q - OCT_STEP;
          oct_q <= oct_q + 1'b1;
        end
      end
      S_G1: g_q <= tk + 18'(interp[28:16]);
      S_G2: base_q <= base_full[36:16];
      S_PM: begin
        dvd_q <= DVD_W'(prod_p);
        dvs_q <= M2;
      end
      S_PMW: mm_a_q <= div_rem;
      S_MMW: begin
        saw_hi_q <= r2_hi;
        dvd_q    <= DVD_W'({r1, 16'b0});
        dvs_q    <= M1;
      end
      S_PHW:  ph_q <= div_quot[15:0];
      S_SINW: sine_q <= sin_y;
      S_DONE: begin
        if (out_free) begin
          m_axis_tdata <= {32'(frame_q), sample_d};
          m_axis_tuser <= status_q;
        end
      end
      default: ;
    endcase
  end

endmodule
